// File: hdl/bpdc_pkg.sv
// Package for the button press duration classifier.
// Holds register widths, register indexes, event codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

  localparam int REG_BITS     = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int EVENT_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RELEASE_GAP = 3'd0,
    REG_TAP_MIN     = 3'd1,
    REG_TAP_MAX     = 3'd2,
    REG_LONG_HOLD   = 3'd3,
    REG_RESET_HOLD  = 3'd4,
    REG_SLEEP_IDLE  = 3'd5
  } reg_index_t;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE  = 3'd0,
    EV_TAP   = 3'd1,
    EV_LONG  = 3'd2,
    EV_RESET = 3'd3,
    EV_SLEEP = 3'd4
  } event_t;

  localparam logic [REG_BITS-1:0] RELEASE_GAP_RST = 24'd5000;
  localparam logic [REG_BITS-1:0] TAP_MIN_RST     = 24'd1000;
  localparam logic [REG_BITS-1:0] TAP_MAX_RST     = 24'd15000;
  localparam logic [REG_BITS-1:0] LONG_HOLD_RST   = 24'd50000;
  localparam logic [REG_BITS-1:0] RESET_HOLD_RST  = 24'd100000;
  localparam logic [REG_BITS-1:0] SLEEP_IDLE_RST  = 24'd6000000;

endpackage

`default_nettype wire

// File: hdl/bpdc_in_if.sv
// Input channel of the classifier: valid/ready plus one sampled button level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

`default_nettype wire

// File: hdl/bpdc_out_if.sv
// Output channel of the classifier: valid/ready plus a 3-bit event code.
// Depends on bpdc_pkg for the event width.
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bpdc_pkg::EVENT_BITS-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

// File: hdl/button_press_duration_classifier_top.sv
// Button press duration classifier: counters, compares and a registered result.
// Depends on bpdc_pkg, bpdc_in_if and bpdc_out_if.
//
//  channel  dir  payload                    beat
//  btn      in   button_level (1b)          one sampled level per tick
//  evt      out  event_code (3b)            one event code per input beat
//  cfg      in   cfg_addr (3b), cfg_wdata   one register write per wen cycle
//
// One input beat per cycle while btn.ready is high; its event code appears
// in the output register the cycle after it is accepted. The counter update
// and the event compare are combinational between state and output registers.
// btn.ready is high whenever the output register is empty or being drained.
// Synchronous reset loads the register defaults and clears all counters.
`timescale 1ns / 1ps
`default_nettype none

module button_press_duration_classifier_top #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bpdc_in_if.sink                                btn,
  bpdc_out_if.source                             evt,
  input  wire logic                              cfg_wen,
  input  wire logic [bpdc_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  wire logic [bpdc_pkg::REG_BITS-1:0]     cfg_wdata
);

  // compare width covers both counters and registers
  localparam int CMP_BITS = (COUNT_BITS > bpdc_pkg::REG_BITS) ? COUNT_BITS
                                                              : bpdc_pkg::REG_BITS;
  localparam logic [COUNT_BITS-1:0] FULL = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

  logic [bpdc_pkg::REG_BITS-1:0] release_gap, tap_min, tap_max;
  logic [bpdc_pkg::REG_BITS-1:0] long_hold, reset_hold, sleep_idle;

  logic                  held_flag, held_flag_next;
  logic [COUNT_BITS-1:0] hold_count, hold_count_next;
  logic [COUNT_BITS-1:0] gap_count, gap_count_next;
  logic [COUNT_BITS-1:0] idle_count, idle_count_next;

  bpdc_pkg::event_t event_next;
  logic [bpdc_pkg::EVENT_BITS-1:0] event_reg;
  logic out_valid;
  logic accept;

  logic [COUNT_BITS-1:0] hold1, gap1, gap2, idle1;
  logic                  held2, press_end, tap_hit, long_hit, reset_hit, sleep_hit;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == FULL) ? FULL : v + ONE;
  endfunction

  function automatic logic [CMP_BITS-1:0] cx(input logic [COUNT_BITS-1:0] v);
    return CMP_BITS'(v);
  endfunction

  function automatic logic [CMP_BITS-1:0] rx(input logic [bpdc_pkg::REG_BITS-1:0] v);
    return CMP_BITS'(v);
  endfunction

  assign btn.ready      = !out_valid || evt.ready;
  assign accept         = btn.valid && btn.ready;
  assign evt.valid      = out_valid;
  assign evt.event_code = event_reg;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      release_gap <= bpdc_pkg::RELEASE_GAP_RST;
      tap_min     <= bpdc_pkg::TAP_MIN_RST;
      tap_max     <= bpdc_pkg::TAP_MAX_RST;
      long_hold   <= bpdc_pkg::LONG_HOLD_RST;
      reset_hold  <= bpdc_pkg::RESET_HOLD_RST;
      sleep_idle  <= bpdc_pkg::SLEEP_IDLE_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        bpdc_pkg::REG_RELEASE_GAP: release_gap <= cfg_wdata;
        bpdc_pkg::REG_TAP_MIN:     tap_min     <= cfg_wdata;
        bpdc_pkg::REG_TAP_MAX:     tap_max     <= cfg_wdata;
        bpdc_pkg::REG_LONG_HOLD:   long_hold   <= cfg_wdata;
        bpdc_pkg::REG_RESET_HOLD:  reset_hold  <= cfg_wdata;
        bpdc_pkg::REG_SLEEP_IDLE:  sleep_idle  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    hold1 = held_flag ? sat_inc(hold_count) : hold_count;
    gap1  = held_flag ? sat_inc(gap_count)  : gap_count;
    idle1 = held_flag ? '0 : idle_count;

    held2 = held_flag || btn.button_level;
    gap2  = btn.button_level ? '0 : gap1;

    press_end = cx(gap2) >= rx(release_gap);
    tap_hit   = press_end && (cx(hold1) > rx(tap_min)) && (cx(hold1) < rx(tap_max));

    held_flag_next  = press_end ? 1'b0 : held2;
    hold_count_next = press_end ? '0 : hold1;
    gap_count_next  = press_end ? '0 : gap2;

    // a saturated counter never matches
    long_hit  = (hold_count_next != FULL) && (cx(hold_count_next) == rx(long_hold));
    reset_hit = (hold_count_next != FULL) && !long_hit &&
                (cx(hold_count_next) == rx(reset_hold));
    sleep_hit = (idle1 != FULL) && (cx(idle1) == rx(sleep_idle));

    idle_count_next = sat_inc(idle1);

    if (tap_hit)        event_next = bpdc_pkg::EV_TAP;
    else if (long_hit)  event_next = bpdc_pkg::EV_LONG;
    else if (reset_hit) event_next = bpdc_pkg::EV_RESET;
    else if (sleep_hit) event_next = bpdc_pkg::EV_SLEEP;
    else                event_next = bpdc_pkg::EV_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag  <= 1'b0;
      hold_count <= '0;
      gap_count  <= '0;
      idle_count <= '0;
    end else if (accept) begin
      held_flag  <= held_flag_next;
      hold_count <= hold_count_next;
      gap_count  <= gap_count_next;
      idle_count <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_reg <= event_next;
    end
  end

  // no press in progress means no hold or gap time pending
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !held_flag |-> (hold_count == '0 && gap_count == '0))
    else $error("hold or gap count nonzero without a press");

  a_tap_needs_press: assert property (@(posedge clk) disable iff (rst)
    (accept && event_next == bpdc_pkg::EV_TAP) |-> held_flag)
    else $error("tap reported without a press in progress");

  a_idle_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && held_flag) |=> (idle_count == ONE))
    else $error("idle count not restarted by a held tick");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for button_press_duration_classifier_top.
// Streams button levels through the valid/ready channels and checks every
// event code against a cycle-free model. Depends on bpdc_pkg, bpdc_in_if, bpdc_out_if.
`timescale 1ns / 1ps

module tb;

  localparam int COUNT_W = 24;
  localparam logic [COUNT_W-1:0] FULL_SCALE = '1;
  localparam logic [bpdc_pkg::REG_BITS-1:0] REG_ALL_ONES = '1;
  // indexes past the last register; writes there must be dropped
  localparam logic [bpdc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bpdc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [bpdc_pkg::CFG_IDX_BITS-1:0] cfg_addr;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_wdata;

  bpdc_in_if  btn ();
  bpdc_out_if evt ();

  button_press_duration_classifier_top #(
    .COUNT_BITS(COUNT_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .btn(btn),
    .evt(evt),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // shadow registers and classifier state
  logic [bpdc_pkg::REG_BITS-1:0] cfg_release_gap = bpdc_pkg::RELEASE_GAP_RST;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_tap_min     = bpdc_pkg::TAP_MIN_RST;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_tap_max     = bpdc_pkg::TAP_MAX_RST;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_long_hold   = bpdc_pkg::LONG_HOLD_RST;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_reset_hold  = bpdc_pkg::RESET_HOLD_RST;
  logic [bpdc_pkg::REG_BITS-1:0] cfg_sleep_idle  = bpdc_pkg::SLEEP_IDLE_RST;

  logic               pressed     = 1'b0;
  logic [COUNT_W-1:0] hold_ticks  = '0;
  logic [COUNT_W-1:0] gap_ticks   = '0;
  logic [COUNT_W-1:0] idle_ticks  = '0;

  bpdc_pkg::event_t expected_events[$];
  int unsigned mismatch_count = 0;
  int unsigned sink_hold_cycles = 0;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
    return (v == FULL_SCALE) ? v : v + 1'b1;
  endfunction

  function automatic bpdc_pkg::event_t classify_level(input logic level);
    bpdc_pkg::event_t ev;
    ev = bpdc_pkg::EV_NONE;
    if (pressed) begin
      hold_ticks = sat_bump(hold_ticks);
      gap_ticks  = sat_bump(gap_ticks);
      idle_ticks = '0;
    end
    if (level) begin
      pressed   = 1'b1;
      gap_ticks = '0;
    end
    if (gap_ticks >= cfg_release_gap) begin
      if (hold_ticks > cfg_tap_min && hold_ticks < cfg_tap_max)
        ev = bpdc_pkg::EV_TAP;
      pressed    = 1'b0;
      hold_ticks = '0;
      gap_ticks  = '0;
    end
    // saturated counts never match; tap outranks long, long outranks reset
    if (hold_ticks != FULL_SCALE && ev == bpdc_pkg::EV_NONE) begin
      if (hold_ticks == cfg_long_hold)
        ev = bpdc_pkg::EV_LONG;
      else if (hold_ticks == cfg_reset_hold)
        ev = bpdc_pkg::EV_RESET;
    end
    if (idle_ticks != FULL_SCALE && idle_ticks == cfg_sleep_idle &&
        ev == bpdc_pkg::EV_NONE)
      ev = bpdc_pkg::EV_SLEEP;
    idle_ticks = sat_bump(idle_ticks);
    return ev;
  endfunction

  // result checker
  always @(posedge clk) begin
    bpdc_pkg::event_t exp_ev;
    if (!rst && evt.valid === 1'b1 && evt.ready === 1'b1) begin
      if (expected_events.size() == 0) begin
        $error("event_code: no beat expected, got %0d", evt.event_code);
        mismatch_count++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (evt.event_code !== exp_ev) begin
          $error("event_code mismatch: expected %0d, actual %0d", exp_ev, evt.event_code);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off whenever sink_hold_cycles is set
  always @(negedge clk) begin
    if (sink_hold_cycles != 0) begin
      evt.ready <= 1'b0;
      sink_hold_cycles = sink_hold_cycles - 1;
    end else begin
      evt.ready <= !(sink_stalls && $urandom_range(99) < 14);
    end
  end

  task automatic send_level(input logic level);
    while (sender_gaps && $urandom_range(99) < 14) begin
      btn.valid        <= 1'b0;
      btn.button_level <= 1'($urandom_range(1));
      @(negedge clk);
    end
    btn.valid        <= 1'b1;
    btn.button_level <= level;
    @(posedge clk);
    while (btn.ready !== 1'b1) @(posedge clk);
    expected_events.push_back(classify_level(level));
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int count);
    for (int i = 0; i < count; i++) send_level(level);
  endtask

  // drop valid and let every outstanding beat drain
  task automatic wait_idle();
    btn.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // leaves cfg_wen high; caller lowers it after the last write
  task automatic write_reg(input logic [bpdc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bpdc_pkg::REG_BITS-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      bpdc_pkg::REG_RELEASE_GAP: cfg_release_gap = val;
      bpdc_pkg::REG_TAP_MIN:     cfg_tap_min     = val;
      bpdc_pkg::REG_TAP_MAX:     cfg_tap_max     = val;
      bpdc_pkg::REG_LONG_HOLD:   cfg_long_hold   = val;
      bpdc_pkg::REG_RESET_HOLD:  cfg_reset_hold  = val;
      bpdc_pkg::REG_SLEEP_IDLE:  cfg_sleep_idle  = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [bpdc_pkg::REG_BITS-1:0] rel_gap,
                           input logic [bpdc_pkg::REG_BITS-1:0] t_min,
                           input logic [bpdc_pkg::REG_BITS-1:0] t_max,
                           input logic [bpdc_pkg::REG_BITS-1:0] lng,
                           input logic [bpdc_pkg::REG_BITS-1:0] rst_hold,
                           input logic [bpdc_pkg::REG_BITS-1:0] slp);
    wait_idle();
    write_reg(bpdc_pkg::REG_RELEASE_GAP, rel_gap);
    write_reg(bpdc_pkg::REG_TAP_MIN, t_min);
    write_reg(bpdc_pkg::REG_TAP_MAX, t_max);
    write_reg(bpdc_pkg::REG_LONG_HOLD, lng);
    write_reg(bpdc_pkg::REG_RESET_HOLD, rst_hold);
    write_reg(bpdc_pkg::REG_SLEEP_IDLE, slp);
    cfg_wen <= 1'b0;
  endtask

  task automatic configure_random();
    logic [bpdc_pkg::REG_BITS-1:0] t_min;
    t_min = bpdc_pkg::REG_BITS'($urandom_range(10, 0));
    configure(bpdc_pkg::REG_BITS'($urandom_range(12, 1)), t_min,
              t_min + bpdc_pkg::REG_BITS'($urandom_range(20, 0)),
              bpdc_pkg::REG_BITS'($urandom_range(40, 1)),
              bpdc_pkg::REG_BITS'($urandom_range(60, 1)),
              bpdc_pkg::REG_BITS'($urandom_range(80, 1)));
  endtask

  // mostly press / release shapes sized around the thresholds, some raw noise
  task automatic drive_press_bursts(input int n_beats);
    int sent;
    int len;
    int hold_span;
    int gap_span;
    int idle_span;
    sent      = 0;
    hold_span = int'(cfg_reset_hold > cfg_long_hold ? cfg_reset_hold : cfg_long_hold) + 4;
    gap_span  = 2 * int'(cfg_release_gap) + 1;
    idle_span = int'(cfg_sleep_idle) + int'(cfg_release_gap) + 10;
    if (hold_span > 120) hold_span = 120;
    if (gap_span > 60) gap_span = 60;
    if (idle_span > 200) idle_span = 200;
    while (sent < n_beats) begin
      if ($urandom_range(99) < 75) begin
        len = $urandom_range(hold_span, 1);
        for (int i = 0; i < len && sent < n_beats; i++) begin
          // short bounce to zero inside the press
          send_level(!(i > 0 && $urandom_range(9) == 0));
          sent++;
        end
        len = ($urandom_range(99) < 15) ? $urandom_range(idle_span, 0)
                                        : $urandom_range(gap_span, 0);
        for (int i = 0; i < len && sent < n_beats; i++) begin
          send_level(1'b0);
          sent++;
        end
      end else begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len && sent < n_beats; i++) begin
          send_level(1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_defaults();
    send_run(1'b1, 2);
    send_run(1'b0, 1);
  endtask

  task automatic test_small_thresholds();
    configure(24'd2, 24'd1, 24'd5, 24'd3, 24'd6, 24'd4);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 5);
    send_run(1'b0, 5);
  endtask

  task automatic test_spare_indexes();
    wait_idle();
    write_reg(REG_SPARE_LO, REG_ALL_ONES);
    write_reg(REG_SPARE_HI, '0);
    cfg_wen <= 1'b0;
    send_run(1'b1, 3);
    send_run(1'b0, 3);
  endtask

  // zero thresholds: every tick ends a press, long fires on every cleared count and outranks sleep
  task automatic test_zero_thresholds();
    configure('0, '0, '0, '0, '0, '0);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
  endtask

  task automatic test_full_scale_thresholds();
    configure(REG_ALL_ONES, '0, REG_ALL_ONES, REG_ALL_ONES - 1'b1,
              REG_ALL_ONES - 1'b1, REG_ALL_ONES - 1'b1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      configure_random();
      drive_press_bursts(190);
    end
  endtask

  task automatic test_no_idling();
    configure_random();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    drive_press_bursts(200);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    configure_random();
    drive_press_bursts(60);
    sink_hold_cycles = 150;
    drive_press_bursts(100);
    wait_idle();
    drive_press_bursts(60);
  endtask

  initial begin
    rst              = 1'b1;
    btn.valid        = 1'b0;
    btn.button_level = 1'b0;
    evt.ready        = 1'b0;
    cfg_wen          = 1'b0;
    cfg_addr         = bpdc_pkg::REG_RELEASE_GAP;
    cfg_wdata        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_small_thresholds();
    test_spare_indexes();
    test_zero_thresholds();
    test_full_scale_thresholds();
    test_random_settings();
    test_no_idling();
    test_backpressure();

    wait_idle();
    repeat (8) @(negedge clk);
    if (expected_events.size() != 0) begin
      $error("event_code: %0d beats never arrived", expected_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("button_press_duration_classifier_top test passed");
    end else begin
      $display("button_press_duration_classifier_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("button_press_duration_classifier_top test failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/bpdc_pkg.sv
hdl/bpdc_in_if.sv
hdl/bpdc_out_if.sv
hdl/button_press_duration_classifier_top.sv
tb/tb.sv
